// ----- design/cartesian_to_spherical_core_assert.svh -----
// assertion macros for the cartesian to spherical core
// expects clk and rst_n in the scope of use
`ifndef CARTESIAN_TO_SPHERICAL_CORE_ASSERT_SVH
`define CARTESIAN_TO_SPHERICAL_CORE_ASSERT_SVH

// same-cycle implication
`define CTSP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CTSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/ctsp_pkg.sv -----
// shared constants, types and tables of the cartesian to spherical core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ctsp_pkg;

  localparam int CW          = 16;
  localparam int GB          = 8;
  localparam int DW          = CW + GB + 4;
  localparam int ANG_Q       = 20;
  localparam int AW          = 32;
  localparam int GAIN_W      = 20;
  localparam int AZW         = 15;
  localparam int DIST_W      = 16;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;
  localparam int SQ_LAT      = CW + 3;

  localparam int ANGLE_FRAC_BITS_DEF = 6;
  localparam int ITER_DEF            = 16;

  localparam logic [GAIN_W-1:0] INV_GAIN = GAIN_W'(636750);

  typedef logic signed [DW-1:0] data_t;
  typedef logic signed [AW-1:0] ang_t;
  typedef logic signed [CW-1:0] coord_t;

  localparam ang_t DEG90  = ang_t'(90)  <<< ANG_Q;
  localparam ang_t DEG180 = ang_t'(180) <<< ANG_Q;
  localparam ang_t DEG360 = ang_t'(360) <<< ANG_Q;

  function automatic ang_t atan_tab(input logic [4:0] idx);
    ang_t t;
    case (idx)
      5'd0:    t = ang_t'(47185920);
      5'd1:    t = ang_t'(27855475);
      5'd2:    t = ang_t'(14718068);
      5'd3:    t = ang_t'(7471121);
      5'd4:    t = ang_t'(3750058);
      5'd5:    t = ang_t'(1876857);
      5'd6:    t = ang_t'(938658);
      5'd7:    t = ang_t'(469357);
      5'd8:    t = ang_t'(234682);
      5'd9:    t = ang_t'(117342);
      5'd10:   t = ang_t'(58671);
      5'd11:   t = ang_t'(29335);
      5'd12:   t = ang_t'(14668);
      5'd13:   t = ang_t'(7334);
      5'd14:   t = ang_t'(3667);
      5'd15:   t = ang_t'(1833);
      5'd16:   t = ang_t'(917);
      5'd17:   t = ang_t'(458);
      5'd18:   t = ang_t'(229);
      5'd19:   t = ang_t'(115);
      5'd20:   t = ang_t'(57);
      5'd21:   t = ang_t'(29);
      5'd22:   t = ang_t'(14);
      5'd23:   t = ang_t'(7);
      5'd24:   t = ang_t'(4);
      5'd25:   t = ang_t'(2);
      5'd26:   t = ang_t'(1);
      default: t = '0;
    endcase
    return t;
  endfunction

  // fold one turn into [0, 360)
  function automatic ang_t fold_turn(input ang_t v);
    ang_t f;
    f = v;
    if (f < 0) f = f + DEG360;
    if (f >= DEG360) f = f - DEG360;
    if (f < 0) f = '0;
    return f;
  endfunction

endpackage

`default_nettype wire

// ----- design/cartesian_to_spherical_core.sv -----
// top level of the cartesian to spherical core
// depends on ctsp_pkg, ctsp_vec, ctsp_sqrt and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

// Converts one signed 3D point per transfer into azimuth, elevation and
// distance. Fully pipelined: a new point can be taken every clock cycle
// while the output is not stalled. The depth is set by two chained unrolled
// CORDIC units, each with a pre-rotation stage, one stage per iteration and
// a gain-multiply stage; the distance square root runs alongside. A stall on
// the output freezes the whole pipeline, so in_tready follows out_tready
// whenever the last stage holds a result.

module cartesian_to_spherical_core #(
  parameter int ANGLE_FRAC_BITS   = ctsp_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_ITERATIONS = ctsp_pkg::ITER_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // coord_x [15:0], coord_y [31:16], coord_z [47:32]
  input  wire [ctsp_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // azimuth [14:0], elevation [29:15], distance [45:30], zero [47:46]
  output logic [ctsp_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int CW    = ctsp_pkg::CW;
  localparam int VL    = CORDIC_ITERATIONS + 2;
  localparam int TOTAL = 2 * VL + 3;
  localparam int PAD   = 2 * VL + 1 - ctsp_pkg::SQ_LAT;
  localparam int SH    = ctsp_pkg::ANG_Q - ANGLE_FRAC_BITS;
  localparam ctsp_pkg::ang_t FULL = ctsp_pkg::ang_t'(360) <<< ANGLE_FRAC_BITS;
  localparam ctsp_pkg::ang_t HALF = ctsp_pkg::ang_t'(1) <<< (SH - 1);

  logic vld_r [TOTAL];
  logic adv;

  ctsp_pkg::coord_t x_r, y_r, z_r;
  ctsp_pkg::coord_t yd_r   [VL];
  ctsp_pkg::ang_t   a1d_r  [VL];
  logic [ctsp_pkg::DIST_W-1:0] dd_r [PAD];

  ctsp_pkg::ang_t          ang1, ang2;
  logic [ctsp_pkg::DW-1:0] mag1;
  ctsp_pkg::data_t         c1a, c1b, c2a, c2b;
  logic [ctsp_pkg::DIST_W-1:0] sq_dist;

  ctsp_pkg::ang_t vaz_r, vel_r;
  ctsp_pkg::ang_t raz, rel;
  logic [ctsp_pkg::AZW-1:0]    az_r, el_r;
  logic [ctsp_pkg::DIST_W-1:0] dist_r;

  assign adv       = !vld_r[TOTAL-1] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOTAL; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i < TOTAL; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r <= in_tdata[CW-1:0];
      y_r <= in_tdata[2*CW-1:CW];
      z_r <= in_tdata[3*CW-1:2*CW];
    end
  end

  assign c1a = ctsp_pkg::DW'(x_r) <<< ctsp_pkg::GB;
  assign c1b = ctsp_pkg::DW'(z_r) <<< ctsp_pkg::GB;

  ctsp_vec #(.ITER(CORDIC_ITERATIONS)) u_vec_az (
    .clk   (clk),
    .en    (adv),
    .a_i   (c1a),
    .b_i   (c1b),
    .ang_o (ang1),
    .mag_o (mag1)
  );

  ctsp_sqrt u_sqrt (
    .clk    (clk),
    .en     (adv),
    .x_i    (x_r),
    .y_i    (y_r),
    .z_i    (z_r),
    .dist_o (sq_dist)
  );

  // align y, the first angle and the distance with the second cordic
  always_ff @(posedge clk) begin
    if (adv) begin
      yd_r[0]  <= y_r;
      a1d_r[0] <= ang1;
      dd_r[0]  <= sq_dist;
      for (int i = 1; i < VL; i++) begin
        yd_r[i]  <= yd_r[i-1];
        a1d_r[i] <= a1d_r[i-1];
      end
      for (int i = 1; i < PAD; i++) dd_r[i] <= dd_r[i-1];
    end
  end

  assign c2a = signed'(mag1);
  assign c2b = ctsp_pkg::DW'(yd_r[VL-1]) <<< ctsp_pkg::GB;

  ctsp_vec #(.ITER(CORDIC_ITERATIONS)) u_vec_el (
    .clk   (clk),
    .en    (adv),
    .a_i   (c2a),
    .b_i   (c2b),
    .ang_o (ang2),
    .mag_o ()
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      vaz_r <= ctsp_pkg::fold_turn(ctsp_pkg::DEG180 - a1d_r[VL-1]);
      vel_r <= ctsp_pkg::fold_turn(ang2 - ctsp_pkg::DEG90);
    end
  end

  // round half up to the output grid, 360 wraps to 0
  always_comb begin
    raz = (vaz_r + HALF) >>> SH;
    rel = (vel_r + HALF) >>> SH;
    if (raz >= FULL) raz = raz - FULL;
    if (rel >= FULL) rel = rel - FULL;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      az_r   <= raz[ctsp_pkg::AZW-1:0];
      el_r   <= rel[ctsp_pkg::AZW-1:0];
      dist_r <= dd_r[PAD-1];
    end
  end

  assign out_tvalid = vld_r[TOTAL-1];
  assign out_tdata  = ctsp_pkg::OUT_TDATA_W'({dist_r, el_r, az_r});

`include "cartesian_to_spherical_core_assert.svh"

  `CTSP_ASSERT_NEXT(a_hold_valid, out_tvalid && !out_tready, out_tvalid, "result dropped during stall")
  `CTSP_ASSERT_NEXT(a_hold_data, out_tvalid && !out_tready, $stable(out_tdata), "result changed during stall")
  `CTSP_ASSERT_IMPL(a_ready, out_tvalid && !out_tready, !in_tready, "input taken while pipeline frozen")

endmodule

`default_nettype wire

// ----- design/ctsp_vec.sv -----
// circular cordic in vectoring mode: angle and gain-corrected length
// depends on ctsp_pkg
`timescale 1ns / 1ps
`default_nettype none

module ctsp_vec #(
  parameter int ITER = ctsp_pkg::ITER_DEF
) (
  input  wire                         clk,
  input  wire                         en,
  input  wire ctsp_pkg::data_t        a_i,
  input  wire ctsp_pkg::data_t        b_i,
  output ctsp_pkg::ang_t              ang_o,
  output logic [ctsp_pkg::DW-1:0]     mag_o
);

  localparam int MW = ctsp_pkg::DW + ctsp_pkg::GAIN_W;

  ctsp_pkg::data_t a_r   [ITER+1];
  ctsp_pkg::data_t b_r   [ITER+1];
  ctsp_pkg::ang_t  ang_r [ITER+1];
  logic            z_r   [ITER+1];
  logic            zn_r  [ITER+1];
  logic [ctsp_pkg::DW-1:0] zm_r [ITER+1];

  ctsp_pkg::ang_t          ang_o_r;
  logic [ctsp_pkg::DW-1:0] mag_o_r;

  ctsp_pkg::data_t         pa_nxt, pb_nxt;
  ctsp_pkg::ang_t          pang_nxt;
  logic [MW-1:0]           prod;
  logic [ctsp_pkg::DW-1:0] mag_nxt;

  // pre-rotation into the right half plane
  always_comb begin
    pa_nxt   = a_i;
    pb_nxt   = b_i;
    pang_nxt = '0;
    if (b_i[ctsp_pkg::DW-1]) begin
      if (!a_i[ctsp_pkg::DW-1]) begin
        pa_nxt   = -b_i;
        pb_nxt   = a_i;
        pang_nxt = ctsp_pkg::DEG90;
      end else begin
        pa_nxt   = b_i;
        pb_nxt   = -a_i;
        pang_nxt = -ctsp_pkg::DEG90;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0]   <= pa_nxt;
      b_r[0]   <= pb_nxt;
      ang_r[0] <= pang_nxt;
      z_r[0]   <= (a_i == '0);
      zn_r[0]  <= b_i[ctsp_pkg::DW-1];
      zm_r[0]  <= b_i[ctsp_pkg::DW-1] ? ctsp_pkg::DW'(-b_i) : ctsp_pkg::DW'(b_i);
    end
  end

  for (genvar k = 1; k <= ITER; k++) begin : g_iter
    localparam logic [4:0] IDX = 5'(k - 1);
    ctsp_pkg::data_t da, db;
    ctsp_pkg::ang_t  at;
    assign da = a_r[k-1] >>> (k - 1);
    assign db = b_r[k-1] >>> (k - 1);
    assign at = ctsp_pkg::atan_tab(IDX);
    always_ff @(posedge clk) begin
      if (en) begin
        if (!a_r[k-1][ctsp_pkg::DW-1]) begin
          b_r[k]   <= b_r[k-1] + da;
          a_r[k]   <= a_r[k-1] - db;
          ang_r[k] <= ang_r[k-1] + at;
        end else begin
          b_r[k]   <= b_r[k-1] - da;
          a_r[k]   <= a_r[k-1] + db;
          ang_r[k] <= ang_r[k-1] - at;
        end
        z_r[k]  <= z_r[k-1];
        zn_r[k] <= zn_r[k-1];
        zm_r[k] <= zm_r[k-1];
      end
    end
  end

  // gain correction, rounded half up
  assign prod    = MW'(unsigned'(b_r[ITER])) * MW'(ctsp_pkg::INV_GAIN)
                 + (MW'(1) << (ctsp_pkg::ANG_Q - 1));
  assign mag_nxt = prod[ctsp_pkg::ANG_Q +: ctsp_pkg::DW];

  always_ff @(posedge clk) begin
    if (en) begin
      if (z_r[ITER]) begin
        ang_o_r <= zn_r[ITER] ? ctsp_pkg::DEG180 : '0;
        mag_o_r <= zm_r[ITER];
      end else begin
        ang_o_r <= ang_r[ITER];
        mag_o_r <= mag_nxt;
      end
    end
  end

  assign ang_o = ang_o_r;
  assign mag_o = mag_o_r;

endmodule

`default_nettype wire

// ----- design/ctsp_sqrt.sv -----
// pipelined rounded integer square root of x*x + y*y + z*z
// depends on ctsp_pkg
`timescale 1ns / 1ps
`default_nettype none

module ctsp_sqrt (
  input  wire                            clk,
  input  wire                            en,
  input  wire ctsp_pkg::coord_t          x_i,
  input  wire ctsp_pkg::coord_t          y_i,
  input  wire ctsp_pkg::coord_t          z_i,
  output logic [ctsp_pkg::DIST_W-1:0]    dist_o
);

  localparam int CW = ctsp_pkg::CW;
  localparam int RW = 2 * CW;
  localparam int MW = CW + 2;

  logic [RW-1:0] sx_r, sy_r, sz_r;
  logic [RW-1:0] rad_r  [CW+1];
  logic [MW-1:0] rem_r  [CW+1];
  logic [CW-1:0] root_r [CW+1];
  logic [ctsp_pkg::DIST_W-1:0] dist_r;

  logic signed [RW-1:0] px, py, pz;
  logic [CW:0]          rnd;

  assign px = RW'(x_i) * RW'(x_i);
  assign py = RW'(y_i) * RW'(y_i);
  assign pz = RW'(z_i) * RW'(z_i);

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r      <= unsigned'(px);
      sy_r      <= unsigned'(py);
      sz_r      <= unsigned'(pz);
      rad_r[0]  <= sx_r + sy_r + sz_r;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  // one result bit per stage
  for (genvar k = 1; k <= CW; k++) begin : g_step
    logic [MW+1:0] t, trial;
    assign t     = {rem_r[k-1], rad_r[k-1][RW-1 -: 2]};
    assign trial = (MW+2)'({root_r[k-1], 2'b01});
    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k] <= rad_r[k-1] << 2;
        if (t >= trial) begin
          rem_r[k]  <= MW'(t - trial);
          root_r[k] <= {root_r[k-1][CW-2:0], 1'b1};
        end else begin
          rem_r[k]  <= MW'(t);
          root_r[k] <= {root_r[k-1][CW-2:0], 1'b0};
        end
      end
    end
  end

  assign rnd = (rem_r[CW] > MW'(root_r[CW])) ? ((CW+1)'(root_r[CW]) + 1'b1)
                                             : (CW+1)'(root_r[CW]);

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= rnd[ctsp_pkg::DIST_W-1:0];
    end
  end

  assign dist_o = dist_r;

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// self-checking bench for cartesian_to_spherical_core: random and directed points,
// expected azimuth, elevation and distance come from an in-bench cordic predictor
// depends on ctsp_pkg and the core rtl
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } point_t;

  // azimuth in the lowest bits, distance in the highest
  typedef struct packed {
    logic [15:0] distance;
    logic [14:0] elevation;
    logic [14:0] azimuth;
  } polar_t;

  localparam int ITERS = 16;
  localparam int ANG_Q = 20;
  localparam int FRAC = 6;
  localparam longint DEG_90 = 64'sd90 <<< ANG_Q;
  localparam longint DEG_180 = 64'sd180 <<< ANG_Q;
  localparam longint DEG_360 = 64'sd360 <<< ANG_Q;
  localparam longint ARCTAN_DEG [0:15] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ctsp_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ctsp_pkg::OUT_TDATA_W-1:0] out_tdata;

  point_t pending_points[$];
  polar_t expected_polar[$];
  point_t cur_point;
  int send_gap = 0;
  int recv_stall = 0;
  bit send_busy_mode = 1'b1;
  bit recv_busy_mode = 1'b1;
  int mismatches = 0;

  cartesian_to_spherical_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #1 clk = ~clk;

  // atan2(a, b) in degrees with ANG_Q fraction bits, plus gain-corrected length
  function automatic longint cordic_atan2(input longint a_in, input longint b_in,
                                          output longint unsigned len);
    longint a, b, ang, t, da, db;
    a = a_in;
    b = b_in;
    ang = 0;
    if (a == 0) begin
      len = (b < 0) ? longint'(-b) : b;
      return (b >= 0) ? 0 : DEG_180;
    end
    if (b < 0) begin
      if (a >= 0) begin
        t = a; a = -b; b = t; ang = DEG_90;
      end else begin
        t = -a; a = b; b = t; ang = -DEG_90;
      end
    end
    for (int i = 0; i < ITERS; i++) begin
      da = a >>> i;
      db = b >>> i;
      if (a >= 0) begin
        b += da; a -= db; ang += ARCTAN_DEG[i];
      end else begin
        b -= da; a += db; ang -= ARCTAN_DEG[i];
      end
    end
    len = (longint'(b) * 64'd636750 + (64'd1 << (ANG_Q - 1))) >> ANG_Q;
    return ang;
  endfunction

  function automatic logic [14:0] quantize_angle(input longint v_in);
    longint v;
    longint unsigned r;
    v = v_in;
    if (v < 0) v += DEG_360;
    if (v >= DEG_360) v -= DEG_360;
    if (v < 0) v = 0;
    r = (longint'(v) + (64'd1 << (ANG_Q - FRAC - 1))) >> (ANG_Q - FRAC);
    if (r >= (64'd360 << FRAC)) r -= (64'd360 << FRAC);
    return r[14:0];
  endfunction

  function automatic longint unsigned rounded_sqrt(input longint unsigned s_in);
    longint unsigned s, res, bitv;
    s = s_in;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return (s > res) ? res + 1 : res;
  endfunction

  function automatic polar_t to_polar(input point_t p);
    polar_t r;
    longint x, y, z, a1, a2;
    longint unsigned horiz, unused_len;
    x = p.x;
    y = p.y;
    z = p.z;
    a1 = cordic_atan2(x <<< 8, z <<< 8, horiz);
    a2 = cordic_atan2(longint'(horiz), y <<< 8, unused_len);
    r.azimuth = quantize_angle(DEG_180 - a1);
    r.elevation = quantize_angle(a2 - DEG_90);
    r.distance = 16'(rounded_sqrt(longint'(x * x + y * y + z * z)));
    return r;
  endfunction

  function automatic logic signed [15:0] random_coord();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 40) return 16'($urandom);
    if (kind < 70) return 16'($urandom_range(0, 127) - 64);
    if (kind < 85) return '0;
    if (kind < 92) return 16'sh7fff - 16'($urandom_range(0, 3));
    return 16'sh8000 + 16'($urandom_range(0, 3));
  endfunction

  function automatic int draw_wait(input bit busy);
    return busy ? $urandom_range(0, 16) : 0;
  endfunction

  // input side
  always @(posedge clk) begin
    logic next_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      next_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        expected_polar.push_back(to_polar(cur_point));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_points.size() > 0) begin
          cur_point = pending_points.pop_front();
          in_tdata <= {cur_point.z, cur_point.y, cur_point.x};
          next_valid = 1'b1;
          if ($urandom_range(0, 49) == 0) send_busy_mode = ~send_busy_mode;
          send_gap = draw_wait(send_busy_mode);
        end
      end
      in_tvalid <= next_valid;
    end
  end

  // output side
  always @(posedge clk) begin
    polar_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[45:0];
        if (expected_polar.size() == 0) begin
          $error("unexpected result transfer %h", out_tdata);
          mismatches++;
        end else begin
          want = expected_polar.pop_front();
          if (got.azimuth !== want.azimuth) begin
            $error("azimuth expected %0d got %0d", want.azimuth, got.azimuth);
            mismatches++;
          end
          if (got.elevation !== want.elevation) begin
            $error("elevation expected %0d got %0d", want.elevation, got.elevation);
            mismatches++;
          end
          if (got.distance !== want.distance) begin
            $error("distance expected %0d got %0d", want.distance, got.distance);
            mismatches++;
          end
        end
        if ($urandom_range(0, 49) == 0) recv_busy_mode = ~recv_busy_mode;
        recv_stall = draw_wait(recv_busy_mode);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic add_point(input int x, input int y, input int z);
    point_t p;
    p.x = 16'(x);
    p.y = 16'(y);
    p.z = 16'(z);
    pending_points.push_back(p);
  endtask

  initial begin
    // origin, axes, vertical axis, zero numerator with negative b, extremes
    add_point(0, 0, 0);
    add_point(0, 100, 0);
    add_point(0, -100, 0);
    add_point(0, 0, 500);
    add_point(0, 0, -500);
    add_point(500, 0, 0);
    add_point(-500, 0, 0);
    add_point(32767, 32767, 32767);
    add_point(-32768, -32768, -32768);
    add_point(-32768, 32767, -32768);
    add_point(32767, -32768, 0);
    add_point(0, 32767, -32768);
    add_point(-32768, 0, 32767);
    add_point(1, 0, -1);
    add_point(-1, 0, -1);
    add_point(-1, 1, 0);
    add_point(1, -1, 1);
    add_point(0, 0, -32768);
    add_point(-32768, 0, 0);
    add_point(0, -32768, 0);
    add_point(1, 0, 0);
    add_point(-1, -1, -1);
    for (int i = 0; i < 1130; i++) begin
      add_point(random_coord(), random_coord(), random_coord());
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_points.size() == 0 && !in_tvalid && expected_polar.size() == 0);
    repeat (80) @(posedge clk);
    if (expected_polar.size() != 0) begin
      $error("%0d results never arrived", expected_polar.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/ctsp_pkg.sv
design/ctsp_vec.sv
design/ctsp_sqrt.sv
design/cartesian_to_spherical_core.sv
bench/tb.sv
